// ===== rtl/bwq_pkg.sv =====
// Package for the batch work queue: item structs, op codes, sizing constants.
// Used by every module under rtl/.
`default_nettype none
package bwq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned CountBitsDef  = 16;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned WmBits        = 20;
  localparam int unsigned QOne          = 65536;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_HASHRATE_KNOWN = 1'b0,
    CFG_HASHRATE       = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] job_tag;
    logic [31:0] job_epoch;
    logic [15:0] job_count;
    logic [15:0] request_count;
    logic [31:0] new_epoch;
  } in_item_t;

  typedef struct packed {
    logic        batch_valid;
    logic [15:0] batch_tag;
    logic [15:0] batch_offset;
    logic [15:0] batch_len;
    logic        last;
    logic [15:0] total_taken;
    logic [16:0] proportion;
    logic [31:0] epoch_out;
    logic        drained;
  } out_item_t;

  // Command passed from front to back: only pops and clears travel.
  typedef struct packed {
    logic        is_clear;
    logic [15:0] request_count;
    logic [31:0] new_epoch;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/bwq_cmd_fifo.sv =====
// Short command queue between the front (classifier) and back (pop engine).
// Depends on bwq_pkg.
`default_nettype none
module bwq_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  bwq_pkg::cmd_t      wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output bwq_pkg::cmd_t      rd_data,
  output logic               empty
);
  import bwq_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bwq_divider.sv =====
// Restoring divider: quotient of (num << 16) / den, one bit per cycle.
// Depends on bwq_pkg.
`default_nettype none
module bwq_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [23:0] den,
  output logic             busy,
  output logic [16:0]      quot
);
  import bwq_pkg::*;

  logic [24:0] rem_r;
  logic [47:0] num_r;
  logic [16:0] q_r;
  logic [5:0]  step_r;
  logic [23:0] den_r;
  logic [24:0] trial;

  assign busy  = (step_r != 6'd0);
  assign quot  = q_r;
  assign trial = {rem_r[23:0], num_r[47]};

  // Shift one dividend bit per cycle; keep low 17 quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 6'd0;
    end else if (start) begin
      step_r <= 6'd48;
      num_r  <= {num, 16'd0};
      rem_r  <= 25'd0;
      q_r    <= 17'd0;
      den_r  <= den;
    end else if (busy) begin
      step_r <= step_r - 6'd1;
      num_r  <= {num_r[46:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[15:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bwq_engine.sv =====
// Back part: job storage, pop walker, watermark, proportion and result queue.
// Depends on bwq_pkg and bwq_divider.
`default_nettype none
module bwq_engine #(
  parameter int unsigned QUEUE_DEPTH = bwq_pkg::QueueDepthDef,
  parameter int unsigned COUNT_BITS  = bwq_pkg::CountBitsDef
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  // job pushes straight from the front
  input  wire logic           push_en,
  input  wire logic [15:0]    push_tag,
  input  wire logic [COUNT_BITS-1:0] push_count,
  output logic                queue_full,
  output logic [31:0]         clean_epoch,
  // commands
  input  bwq_pkg::cmd_t       cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_take,
  output logic                busy,
  input  wire logic           hashrate_known,
  input  wire logic [31:0]    hashrate,
  // results
  output bwq_pkg::out_item_t  out_data,
  output logic                out_empty,
  input  wire logic           out_pop
);
  import bwq_pkg::*;

  localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);
  localparam int unsigned OccBits = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RqBits  = $clog2(MaxResults);
  localparam int unsigned RcBits  = $clog2(MaxResults + 1);
  localparam logic [WmBits-1:0] WmMax = '1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_STEP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r;

  logic [15:0]           tag_mem_r [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem_r [QUEUE_DEPTH];
  logic [15:0]           rd_tag_r;
  logic [COUNT_BITS-1:0] rd_cnt_r;

  logic [PtrBits-1:0]    head_r, tail_r;
  logic [OccBits-1:0]    occ_r;
  logic [COUNT_BITS-1:0] cursor_r;
  logic [WmBits-1:0]     wm_r;
  logic [31:0]           epoch_r;

  logic [15:0]           want_r, total_r;
  logic [RcBits-1:0]     nres_r;
  logic                  div_start, div_busy;
  logic [16:0]           div_q;

  // result queue
  out_item_t             rq_mem_r [MaxResults];
  logic [RqBits-1:0]     rq_wp_r, rq_rp_r;
  logic [RcBits-1:0]     rq_cnt_r;
  logic                  rq_wr;
  out_item_t             rq_wdata;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    logic [PtrBits-1:0] r;
    if ({{(32-PtrBits){1'b0}}, p} == QUEUE_DEPTH - 1) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign queue_full  = (occ_r == OccBits'(QUEUE_DEPTH));
  assign clean_epoch = epoch_r;
  assign busy        = (state_r != ST_IDLE);
  assign cmd_take    = (state_r == ST_IDLE) && cmd_valid && (rq_cnt_r == '0);

  // Step arithmetic on the read head entry
  logic [COUNT_BITS-1:0] rem;
  logic [15:0]           need;
  logic [15:0]           take;
  logic                  fin;
  logic                  head_done;
  logic [COUNT_BITS:0]   cur_sum;
  always_comb begin
    rem    = (rd_cnt_r > cursor_r) ? rd_cnt_r - cursor_r : '0;
    need   = want_r - total_r;
    // take never exceeds rem, so narrowing it back to COUNT_BITS is safe
    take   = (33'(rem) > 33'(need)) ? need : 16'(rem);
    cur_sum   = {1'b0, cursor_r} + (COUNT_BITS+1)'(take);
    head_done = (rem == '0) || (cur_sum >= {1'b0, rd_cnt_r});
    fin = (occ_r == '0) || (total_r >= want_r) || (nres_r == RcBits'(MaxResults));
  end

  // Proportion result
  logic [23:0] wm10;
  logic [16:0] prop;
  assign wm10 = {wm_r, 3'd0} + {1'b0, wm_r, 1'b0} + 24'd0;
  always_comb begin
    if (!hashrate_known || wm10 == '0 || {8'd0, hashrate} > {16'd0, wm10}) prop = 17'(QOne);
    else prop = div_q;
  end

  bwq_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(hashrate), .den(wm10), .busy(div_busy), .quot(div_q)
  );

  // Storage writes and registered reads
  always_ff @(posedge clk) begin
    if (push_en) begin
      tag_mem_r[tail_r] <= push_tag;
      cnt_mem_r[tail_r] <= push_count;
    end
    rd_tag_r <= tag_mem_r[head_r];
    rd_cnt_r <= cnt_mem_r[head_r];
  end

  // Pop walker
  always_comb begin
    div_start = 1'b0;
    rq_wr     = 1'b0;
    rq_wdata  = '0;
    if (state_r == ST_STEP) begin
      if (fin) div_start = 1'b1;
      else if (rem != '0) begin
        rq_wr = 1'b1;
        rq_wdata.batch_valid  = 1'b1;
        rq_wdata.batch_tag    = rd_tag_r;
        rq_wdata.batch_offset = 16'(cursor_r);
        rq_wdata.batch_len    = take;
      end
    end else if (state_r == ST_DONE) begin
      rq_wr = 1'b1;
      rq_wdata.last        = 1'b1;
      rq_wdata.total_taken = total_r;
      rq_wdata.proportion  = prop;
      rq_wdata.epoch_out   = epoch_r;
      rq_wdata.drained     = (wm_r == '0);
    end
  end

  logic merge_last;
  // Last item folds into the final batch if one was written
  assign merge_last = (state_r == ST_DONE) && (nres_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r <= '0; tail_r <= '0; occ_r <= '0; cursor_r <= '0;
      wm_r <= '0; epoch_r <= '0;
      want_r <= '0; total_r <= '0; nres_r <= '0;
    end else begin
      if (push_en) begin
        tail_r <= next_ptr(tail_r);
        occ_r  <= occ_r + 1'b1;
        if ({1'b0, wm_r} + (WmBits+1)'(push_count) > {1'b0, WmMax}) wm_r <= WmMax;
        else wm_r <= wm_r + WmBits'(push_count);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd.is_clear) begin
              head_r <= '0; tail_r <= '0; occ_r <= '0; cursor_r <= '0;
              wm_r <= '0; epoch_r <= cmd.new_epoch;
            end else begin
              want_r <= cmd.request_count; total_r <= '0; nres_r <= '0;
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: state_r <= ST_STEP;
        ST_STEP: begin
          if (fin) state_r <= ST_DIV;
          else begin
            if (rem != '0) begin
              nres_r  <= nres_r + 1'b1;
              total_r <= total_r + take;
              wm_r    <= (wm_r >= WmBits'(take)) ? wm_r - WmBits'(take) : '0;
            end
            if (head_done) begin
              cursor_r <= '0;
              head_r   <= next_ptr(head_r);
              occ_r    <= occ_r - 1'b1;
            end else begin
              cursor_r <= COUNT_BITS'(cur_sum);
            end
            state_r <= ST_READ;
          end
        end
        ST_DIV: if (!div_busy && !div_start) state_r <= ST_DONE;
        ST_DONE: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result queue storage
  logic [RqBits-1:0] rq_last_idx;
  assign rq_last_idx = rq_wp_r - 1'b1;
  always_ff @(posedge clk) begin
    if (rq_wr) begin
      if (merge_last) begin
        rq_mem_r[rq_last_idx].last        <= 1'b1;
        rq_mem_r[rq_last_idx].total_taken <= rq_wdata.total_taken;
        rq_mem_r[rq_last_idx].proportion  <= rq_wdata.proportion;
        rq_mem_r[rq_last_idx].epoch_out   <= rq_wdata.epoch_out;
        rq_mem_r[rq_last_idx].drained     <= rq_wdata.drained;
      end else begin
        rq_mem_r[rq_wp_r] <= rq_wdata;
      end
    end
  end

  // Hold results until the last one is written, then release
  logic rq_hold_r;
  logic rq_do_pop;
  assign out_empty = (rq_cnt_r == '0) || rq_hold_r;
  assign out_data  = rq_mem_r[rq_rp_r];
  assign rq_do_pop = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r <= '0; rq_rp_r <= '0; rq_cnt_r <= '0; rq_hold_r <= 1'b0;
    end else begin
      if (state_r == ST_READ) rq_hold_r <= 1'b1;
      if (state_r == ST_DONE) rq_hold_r <= 1'b0;
      if (rq_wr && !merge_last) rq_wp_r <= rq_wp_r + 1'b1;
      if (rq_do_pop) rq_rp_r <= rq_rp_r + 1'b1;
      rq_cnt_r <= rq_cnt_r + RcBits'(rq_wr && !merge_last) - RcBits'(rq_do_pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bwq_front.sv =====
// Front part: accepts items, filters and issues pushes, queues pops and clears.
// Depends on bwq_pkg.
`default_nettype none
module bwq_front #(
  parameter int unsigned COUNT_BITS = bwq_pkg::CountBitsDef
) (
  input  wire logic            in_push,
  input  bwq_pkg::in_item_t    in_data,
  output logic                 in_full,
  input  wire logic            engine_busy,
  input  wire logic            cmd_pending,
  input  wire logic            queue_full,
  input  wire logic [31:0]     clean_epoch,
  input  wire logic            cmd_full,
  output logic                 push_en,
  output logic [COUNT_BITS-1:0] push_count,
  output logic                 cmd_wr,
  output bwq_pkg::cmd_t        cmd
);
  import bwq_pkg::*;

  logic acc;
  // Pushes wait while a pop or clear is in flight, keeping program order
  assign in_full    = cmd_full || engine_busy || cmd_pending;
  assign acc        = in_push && !in_full;
  assign push_count = COUNT_BITS'(in_data.job_count);

  // Classify the accepted item
  always_comb begin
    push_en = 1'b0;
    cmd_wr  = 1'b0;
    cmd.is_clear      = (kind_t'(in_data.kind) == KIND_CLEAR);
    cmd.request_count = in_data.request_count;
    cmd.new_epoch     = in_data.new_epoch;
    if (acc) begin
      unique case (kind_t'(in_data.kind))
        KIND_PUSH:  push_en = (in_data.job_epoch >= clean_epoch) &&
                              (push_count != '0) && !queue_full;
        KIND_POP:   cmd_wr = 1'b1;
        KIND_CLEAR: cmd_wr = 1'b1;
        default:    cmd_wr = 1'b0;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/batch_work_queue.sv =====
// Batch work queue top level. A pop walks the head jobs through the READ and
// STEP states, waits on the divider for the proportion, then writes the last
// result; results are held until it is written. The next item waits for the
// pop; a pop or clear also waits until every result is read. Reset (rst_n
// low, sync) empties the job queue and clears watermark, epoch and registers.
`default_nettype none
module batch_work_queue #(
  parameter int unsigned QUEUE_DEPTH = bwq_pkg::QueueDepthDef,
  parameter int unsigned COUNT_BITS  = bwq_pkg::CountBitsDef
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  bwq_pkg::in_item_t    in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output bwq_pkg::out_item_t   out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [31:0]     cfg_data
);
  import bwq_pkg::*;

  logic            hr_known_r;
  logic [31:0]     hashrate_r;
  logic            push_en, cmd_wr, cmd_full, cmd_empty, cmd_take;
  logic            queue_full, engine_busy;
  logic [31:0]     clean_epoch;
  logic [COUNT_BITS-1:0] push_count;
  cmd_t            cmd_in, cmd_out;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hr_known_r <= 1'b0; hashrate_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HASHRATE_KNOWN: hr_known_r <= cfg_data[0];
        CFG_HASHRATE:       hashrate_r <= cfg_data;
        default:            hashrate_r <= hashrate_r;
      endcase
    end
  end

  bwq_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .engine_busy(engine_busy), .cmd_pending(!cmd_empty),
    .queue_full(queue_full), .clean_epoch(clean_epoch), .cmd_full(cmd_full),
    .push_en(push_en), .push_count(push_count), .cmd_wr(cmd_wr), .cmd(cmd_in)
  );

  bwq_cmd_fifo u_cmdq (
    .clk(clk), .rst_n(rst_n), .wr_en(cmd_wr), .wr_data(cmd_in), .full(cmd_full),
    .rd_en(cmd_take), .rd_data(cmd_out), .empty(cmd_empty)
  );

  bwq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .push_en(push_en), .push_tag(in_data.job_tag), .push_count(push_count),
    .queue_full(queue_full), .clean_epoch(clean_epoch),
    .cmd(cmd_out), .cmd_valid(!cmd_empty), .cmd_take(cmd_take), .busy(engine_busy),
    .hashrate_known(hr_known_r), .hashrate(hashrate_r),
    .out_data(out_data), .out_empty(out_empty), .out_pop(out_pop)
  );
endmodule
`default_nettype wire
